// File: rtl/core/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// shared types, sizes and codes of the matrix multiply engine
// ----------------------------------------------------------------------------
package mme_pkg;

  // matrix geometry and element format
  localparam int unsigned DIM    = 16;
  localparam int unsigned IDX_W  = $clog2(DIM);
  localparam int unsigned ADDR_W = 2 * IDX_W;
  localparam int unsigned DEPTH  = DIM * DIM;
  localparam int unsigned ELEM_W = 16;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned SUM_W  = 36;
  localparam int unsigned SIZE_W = 5;

  // configuration port
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // stream words
  localparam int unsigned IN_DW  = 24;
  localparam int unsigned IN_UW  = 2;
  localparam int unsigned OUT_DW = 48;
  localparam int unsigned OUT_UW = 2;

  typedef enum logic [1:0] {
    KIND_WR_A    = 2'd0,
    KIND_WR_B    = 2'd1,
    KIND_COMPUTE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_OK   = 2'd0,
    ERR_SIZE = 2'd1,
    ERR_ROW  = 2'd2
  } err_t;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_RUN   = 2'd1,
    ST_DRAIN = 2'd2
  } state_t;

  // tag that travels alongside each pair of operands
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             lastk;
    logic             lastc;
    logic [IDX_W-1:0] col;
  } tag_t;

  // finished dot product leaving the accumulator
  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] col;
    logic [SUM_W-1:0] sum;
  } res_t;

  // zero counts as one, anything above the store size counts as the store size
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] r);
    logic [SIZE_W-1:0] e;
    begin
      if (r == '0) begin
        e = SIZE_W'(1);
      end else if (r > SIZE_W'(DIM)) begin
        e = SIZE_W'(DIM);
      end else begin
        e = r;
      end
      return e;
    end
  endfunction

endpackage

// File: rtl/core/mme_store.sv
// ----------------------------------------------------------------------------
// mme_store
// single matrix store, one write port and one registered read port
// ----------------------------------------------------------------------------
module mme_store (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [mme_pkg::ADDR_W-1:0] wr_addr,
  input  logic [mme_pkg::ELEM_W-1:0] wr_data,
  input  logic                       rd_en,
  input  logic [mme_pkg::ADDR_W-1:0] rd_addr,
  output logic [mme_pkg::ELEM_W-1:0] rd_data
);

  logic [mme_pkg::ELEM_W-1:0] mem_r [mme_pkg::DEPTH];
  logic [mme_pkg::ELEM_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while the pipeline is frozen
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/core/mme_mac.sv
// ----------------------------------------------------------------------------
// mme_mac
// multiply stage and accumulate stage of the dot product pipeline
// ----------------------------------------------------------------------------
module mme_mac (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       stall,
  input  mme_pkg::tag_t              tag_in,
  input  logic [mme_pkg::ELEM_W-1:0] a_data,
  input  logic [mme_pkg::ELEM_W-1:0] b_data,
  output mme_pkg::res_t              res,
  output logic                       empty
);

  mme_pkg::tag_t                     s1_tag_r;
  mme_pkg::tag_t                     s2_tag_r;
  logic signed [mme_pkg::PROD_W-1:0] prod_r;
  logic signed [mme_pkg::SUM_W-1:0]  acc_r;
  logic signed [mme_pkg::SUM_W-1:0]  sum;
  logic signed [mme_pkg::SUM_W-1:0]  prod_ext;
  logic signed [mme_pkg::ELEM_W-1:0] a_s;
  logic signed [mme_pkg::ELEM_W-1:0] b_s;

  assign a_s = a_data;
  assign b_s = b_data;

  // tags are registered alongside the store read data, so s1 lines up with it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_tag_r <= '0;
      s2_tag_r <= '0;
    end else if (!stall) begin
      s1_tag_r <= tag_in;
      s2_tag_r <= s1_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!stall) begin
      prod_r <= a_s * b_s;
      if (s2_tag_r.valid) begin
        acc_r <= sum;
      end
    end
  end

  assign prod_ext = {{(mme_pkg::SUM_W - mme_pkg::PROD_W){prod_r[mme_pkg::PROD_W-1]}}, prod_r};
  assign sum      = (s2_tag_r.first ? '0 : acc_r) + prod_ext;

  assign res.valid = s2_tag_r.valid && s2_tag_r.lastk;
  assign res.last  = s2_tag_r.lastc;
  assign res.col   = s2_tag_r.col;
  assign res.sum   = sum;

  assign empty = !s1_tag_r.valid && !s2_tag_r.valid;

endmodule

// File: rtl/core/mme_seq.sv
// ----------------------------------------------------------------------------
// mme_seq
// walks columns and inner index of one C row, issuing store reads
// ----------------------------------------------------------------------------
module mme_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       stall,
  input  logic                       start,
  input  logic [mme_pkg::IDX_W-1:0]  start_row,
  input  logic [mme_pkg::SIZE_W-1:0] inner,
  input  logic [mme_pkg::SIZE_W-1:0] ncols,
  input  logic                       pipe_empty,
  output logic                       busy,
  output logic [mme_pkg::IDX_W-1:0]  row,
  output logic                       rd_en,
  output logic [mme_pkg::ADDR_W-1:0] addr_a,
  output logic [mme_pkg::ADDR_W-1:0] addr_b,
  output mme_pkg::tag_t              tag
);

  mme_pkg::state_t                  state_r;
  mme_pkg::state_t                  state_nxt;
  logic [mme_pkg::IDX_W-1:0]        row_r;
  logic [mme_pkg::IDX_W-1:0]        k_r;
  logic [mme_pkg::IDX_W-1:0]        k_nxt;
  logic [mme_pkg::IDX_W-1:0]        c_r;
  logic [mme_pkg::IDX_W-1:0]        c_nxt;
  logic                             issue;
  logic                             k_end;
  logic                             c_end;

  assign k_end = (mme_pkg::SIZE_W'(k_r) + mme_pkg::SIZE_W'(1)) == inner;
  assign c_end = (mme_pkg::SIZE_W'(c_r) + mme_pkg::SIZE_W'(1)) == ncols;
  assign issue = (state_r == mme_pkg::ST_RUN) && !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mme_pkg::ST_IDLE;
      k_r     <= '0;
      c_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      c_r     <= c_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      row_r <= start_row;
    end
  end

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    c_nxt     = c_r;
    case (state_r)
      mme_pkg::ST_IDLE: begin
        k_nxt = '0;
        c_nxt = '0;
        if (start) begin
          state_nxt = mme_pkg::ST_RUN;
        end
      end
      mme_pkg::ST_RUN: begin
        if (issue) begin
          if (k_end) begin
            k_nxt = '0;
            c_nxt = c_r + mme_pkg::IDX_W'(1);
            if (c_end) begin
              state_nxt = mme_pkg::ST_DRAIN;
            end
          end else begin
            k_nxt = k_r + mme_pkg::IDX_W'(1);
          end
        end
      end
      mme_pkg::ST_DRAIN: begin
        if (pipe_empty) begin
          state_nxt = mme_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mme_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_r != mme_pkg::ST_IDLE);
  assign row    = row_r;
  assign rd_en  = issue;
  assign addr_a = {row_r, k_r};
  assign addr_b = {k_r, c_r};

  assign tag.valid = issue;
  assign tag.first = (k_r == '0);
  assign tag.lastk = k_end;
  assign tag.lastc = c_end;
  assign tag.col   = c_r;

  // counters stay inside the configured sizes while reads are issued
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mme_pkg::ST_RUN) |->
      (mme_pkg::SIZE_W'(k_r) < inner) && (mme_pkg::SIZE_W'(c_r) < ncols))
    else $error("inner or column counter beyond configured size");

endmodule

// File: rtl/core/matrix_multiply_engine_core.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_core
// C = A * B on signed Q7.8 elements, one C row per compute word
// ----------------------------------------------------------------------------
// order: an element is written to its store as its word is taken; an error result
//   is in the output register the cycle after its compute word; a column result
//   goes through the store read and product registers into the output register
// flow: a compute word is taken, then its store reads go one per cycle, unless
//   stalled, through the single multiply-accumulate unit, and the pipeline drains
//   before the next word is taken; an output stall freezes the whole pipeline
// reset: rst_n synchronous, active low; sizes go to 16, stores keep contents
// ----------------------------------------------------------------------------
module matrix_multiply_engine_core (
  input  logic                        clk,
  input  logic                        rst_n,

  // input stream
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [mme_pkg::IN_DW-1:0]   in_tdata,   // row[3:0], col[7:4], value[23:8]
  input  logic [mme_pkg::IN_UW-1:0]   in_tuser,   // kind[1:0]

  // result stream
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [mme_pkg::OUT_DW-1:0]  out_tdata,  // out_row[3:0], out_col[7:4],
                                                  // product_value[43:8], zero[47:44]
  output logic [mme_pkg::OUT_UW-1:0]  out_tuser,  // error_code[1:0]
  output logic                        out_tlast,

  // configuration port
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [mme_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [mme_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [mme_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  // size registers
  logic [mme_pkg::SIZE_W-1:0] a_rows_r;
  logic [mme_pkg::SIZE_W-1:0] a_cols_r;
  logic [mme_pkg::SIZE_W-1:0] b_rows_r;
  logic [mme_pkg::SIZE_W-1:0] b_cols_r;
  logic [mme_pkg::SIZE_W-1:0] ar_eff;
  logic [mme_pkg::SIZE_W-1:0] ac_eff;
  logic [mme_pkg::SIZE_W-1:0] br_eff;
  logic [mme_pkg::SIZE_W-1:0] bc_eff;
  mme_pkg::reg_idx_t          cfg_idx;
  logic                       cfg_wr;
  logic [mme_pkg::SIZE_W-1:0] cfg_rd_val;

  // input word fields
  mme_pkg::kind_t             in_kind;
  logic [mme_pkg::IDX_W-1:0]  in_row;
  logic [mme_pkg::IDX_W-1:0]  in_col;
  logic [mme_pkg::ELEM_W-1:0] in_value;
  logic                       in_acc;

  // control
  logic                       stall;
  logic                       busy;
  logic                       start;
  logic                       err_load;
  mme_pkg::err_t              err_code;
  logic                       a_wr_en;
  logic                       b_wr_en;
  logic                       rd_en;
  logic [mme_pkg::ADDR_W-1:0] addr_a;
  logic [mme_pkg::ADDR_W-1:0] addr_b;
  logic [mme_pkg::ADDR_W-1:0] wr_addr;
  logic [mme_pkg::ELEM_W-1:0] a_data;
  logic [mme_pkg::ELEM_W-1:0] b_data;
  logic [mme_pkg::IDX_W-1:0]  seq_row;
  mme_pkg::tag_t              tag;
  mme_pkg::res_t              res;
  logic                       pipe_empty;
  logic                       res_load;

  // output register
  logic                       out_valid_r;
  logic [mme_pkg::IDX_W-1:0]  out_row_r;
  logic [mme_pkg::IDX_W-1:0]  out_col_r;
  logic [mme_pkg::SUM_W-1:0]  out_sum_r;
  mme_pkg::err_t              out_err_r;
  logic                       out_last_r;

  // ---------------------------------------------------------------------------
  // configuration registers, byte address 4 * index
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = mme_pkg::reg_idx_t'(cfg_paddr[mme_pkg::CFG_AW-1:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_rows_r <= mme_pkg::SIZE_W'(mme_pkg::DIM);
      a_cols_r <= mme_pkg::SIZE_W'(mme_pkg::DIM);
      b_rows_r <= mme_pkg::SIZE_W'(mme_pkg::DIM);
      b_cols_r <= mme_pkg::SIZE_W'(mme_pkg::DIM);
    end else if (cfg_wr) begin
      case (cfg_idx)
        mme_pkg::REG_A_ROWS: a_rows_r <= cfg_pwdata[mme_pkg::SIZE_W-1:0];
        mme_pkg::REG_A_COLS: a_cols_r <= cfg_pwdata[mme_pkg::SIZE_W-1:0];
        mme_pkg::REG_B_ROWS: b_rows_r <= cfg_pwdata[mme_pkg::SIZE_W-1:0];
        mme_pkg::REG_B_COLS: b_cols_r <= cfg_pwdata[mme_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      mme_pkg::REG_A_ROWS: cfg_rd_val = a_rows_r;
      mme_pkg::REG_A_COLS: cfg_rd_val = a_cols_r;
      mme_pkg::REG_B_ROWS: cfg_rd_val = b_rows_r;
      mme_pkg::REG_B_COLS: cfg_rd_val = b_cols_r;
      default:             cfg_rd_val = '0;
    endcase
  end

  assign cfg_prdata = mme_pkg::CFG_DW'(cfg_rd_val);

  // out-of-range sizes are clamped before use
  assign ar_eff = mme_pkg::eff_size(a_rows_r);
  assign ac_eff = mme_pkg::eff_size(a_cols_r);
  assign br_eff = mme_pkg::eff_size(b_rows_r);
  assign bc_eff = mme_pkg::eff_size(b_cols_r);

  // ---------------------------------------------------------------------------
  // input decode
  // a new word is only taken once the previous compute has fully drained,
  // so store writes never overlap the reads of a running row
  // ---------------------------------------------------------------------------
  assign stall     = out_valid_r && !out_tready;
  assign in_tready = !busy && !stall;
  assign in_acc    = in_tvalid && in_tready;

  assign in_kind  = mme_pkg::kind_t'(in_tuser);
  assign in_row   = in_tdata[mme_pkg::IDX_W-1:0];
  assign in_col   = in_tdata[2*mme_pkg::IDX_W-1:mme_pkg::IDX_W];
  assign in_value = in_tdata[2*mme_pkg::IDX_W+mme_pkg::ELEM_W-1:2*mme_pkg::IDX_W];
  assign wr_addr  = {in_row, in_col};

  always_comb begin
    a_wr_en  = 1'b0;
    b_wr_en  = 1'b0;
    start    = 1'b0;
    err_load = 1'b0;
    err_code = mme_pkg::ERR_OK;
    case (in_kind)
      mme_pkg::KIND_WR_A: a_wr_en = in_acc;
      mme_pkg::KIND_WR_B: b_wr_en = in_acc;
      mme_pkg::KIND_COMPUTE: begin
        // size mismatch is checked before the row range
        if (ac_eff != br_eff) begin
          err_load = in_acc;
          err_code = mme_pkg::ERR_SIZE;
        end else if (mme_pkg::SIZE_W'(in_row) >= ar_eff) begin
          err_load = in_acc;
          err_code = mme_pkg::ERR_ROW;
        end else begin
          start = in_acc;
        end
      end
      default: ;  // unused kind, dropped without a result
    endcase
  end

  // ---------------------------------------------------------------------------
  // stores, sequencer and multiply-accumulate pipeline
  // ---------------------------------------------------------------------------
  mme_store u_store_a (
    .clk     (clk),
    .wr_en   (a_wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (addr_a),
    .rd_data (a_data)
  );

  mme_store u_store_b (
    .clk     (clk),
    .wr_en   (b_wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_value),
    .rd_en   (rd_en),
    .rd_addr (addr_b),
    .rd_data (b_data)
  );

  mme_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .stall      (stall),
    .start      (start),
    .start_row  (in_row),
    .inner      (ac_eff),
    .ncols      (bc_eff),
    .pipe_empty (pipe_empty),
    .busy       (busy),
    .row        (seq_row),
    .rd_en      (rd_en),
    .addr_a     (addr_a),
    .addr_b     (addr_b),
    .tag        (tag)
  );

  mme_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .stall  (stall),
    .tag_in (tag),
    .a_data (a_data),
    .b_data (b_data),
    .res    (res),
    .empty  (pipe_empty)
  );

  // ---------------------------------------------------------------------------
  // output register; the whole pipeline freezes while it is held
  // ---------------------------------------------------------------------------
  assign res_load = res.valid && !stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load || err_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_row_r  <= seq_row;
      out_col_r  <= res.col;
      out_sum_r  <= res.sum;
      out_err_r  <= mme_pkg::ERR_OK;
      out_last_r <= res.last;
    end else if (err_load) begin
      out_row_r  <= in_row;
      out_col_r  <= '0;
      out_sum_r  <= '0;
      out_err_r  <= err_code;
      out_last_r <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(mme_pkg::OUT_DW - mme_pkg::SUM_W - 2*mme_pkg::IDX_W){1'b0}},
                       out_sum_r, out_col_r, out_row_r};
  assign out_tuser  = out_err_r;
  assign out_tlast  = out_last_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  // no store write while a row is being read
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (a_wr_en || b_wr_en) |-> !busy)
    else $error("store written during a compute");

  // an error result is the only and final result of its word
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_err_r != mme_pkg::ERR_OK)) |->
      (out_last_r && (out_sum_r == '0) && (out_col_r == '0)))
    else $error("error result without last or with payload");

  // the sequencer only starts on an accepted error-free compute word
  a_start_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(in_acc && (in_kind == mme_pkg::KIND_COMPUTE) && !err_load))
    else $error("sequencer started without a compute word");

endmodule
